[rtl/core/assert_macros.svh]
// Assertion macros used by the top level of the histogram block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a condition implies another in the same cycle.
`define ASSERT_SAME(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[rtl/core/rgbh_pkg.sv]
// Types, constants and the bin select function of the color histogram.
`timescale 1ns / 1ps
`default_nettype none
package rgbh_pkg;
  localparam int ChanCount    = 3;
  localparam int BinCount     = 12;
  localparam int TotalBins    = ChanCount * BinCount;
  localparam int CountW       = 10;
  localparam int WindowPixels = 512;
  localparam int CountMax     = (1 << CountW) - 1;
  localparam int CountCapInt  = (WindowPixels < CountMax) ? WindowPixels : CountMax;

  typedef logic [7:0]        byte_t;
  typedef logic [1:0]        chan_t;
  typedef logic [3:0]        bin_t;
  typedef logic [CountW-1:0] count_t;

  localparam count_t CountCap = count_t'(CountCapInt);
  localparam chan_t  LastChan = chan_t'(ChanCount - 1);
  localparam bin_t   LastBin  = bin_t'(BinCount - 1);

  // Lower edge of each bin.
  localparam byte_t BinFloor [BinCount] = '{
    8'd0, 8'd21, 8'd42, 8'd64, 8'd85, 8'd106,
    8'd128, 8'd149, 8'd170, 8'd192, 8'd213, 8'd234
  };

  // Status of the drain stage seen by the top level.
  typedef struct packed {
    logic busy;
    logic final_beat;
  } drain_stat_t;

  // Highest bin whose lower edge does not exceed the byte.
  function automatic bin_t pick_bin(input byte_t v);
    bin_t b;
    b = '0;
    for (int k = 1; k < BinCount; k++) begin
      if (v >= BinFloor[k]) b = bin_t'(k);
    end
    return b;
  endfunction
endpackage
`default_nettype wire

[rtl/core/rgbh_if.sv]
// Stream interfaces: pixel input and histogram count output.
`timescale 1ns / 1ps
`default_nettype none
interface rgbh_pix_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        last_pixel;
  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface rgbh_hist_if;
  logic        valid;
  logic        ready;
  logic [1:0]  channel;
  logic [3:0]  bin;
  logic [9:0]  count;
  logic        last_result;
  modport source (output valid, channel, bin, count, last_result, input ready);
  modport sink   (input valid, channel, bin, count, last_result, output ready);
endinterface
`default_nettype wire

[rtl/core/rgbh_lane.sv]
// One channel lane: bin select and twelve saturating counters.
`timescale 1ns / 1ps
`default_nettype none
module rgbh_lane (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            take,
  input  wire logic            clear,
  input  wire rgbh_pkg::byte_t value,
  output rgbh_pkg::count_t     counts_next [rgbh_pkg::BinCount]
);
  import rgbh_pkg::*;

  count_t counters [BinCount];
  bin_t   sel;

  assign sel = pick_bin(value);

  // Add this pixel to its bin, holding at the cap.
  always_comb begin
    for (int b = 0; b < BinCount; b++) begin
      if (take && (sel == bin_t'(b)) && (counters[b] < CountCap)) begin
        counts_next[b] = counters[b] + count_t'(1);
      end else begin
        counts_next[b] = counters[b];
      end
    end
  end

  // Advance the counters; clear them once the window is handed off.
  always_ff @(posedge clk) begin
    for (int b = 0; b < BinCount; b++) begin
      if (rst || clear) begin
        counters[b] <= '0;
      end else begin
        counters[b] <= counts_next[b];
      end
    end
  end
endmodule
`default_nettype wire

[rtl/core/rgbh_drain.sv]
// Merge stage: snapshot of all lane counts, shifted out one per transfer.
`timescale 1ns / 1ps
`default_nettype none
module rgbh_drain (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire rgbh_pkg::count_t load_counts [rgbh_pkg::TotalBins],
  output rgbh_pkg::drain_stat_t stat,
  rgbh_hist_if.source           hist
);
  import rgbh_pkg::*;

  count_t shadow [TotalBins];
  logic   busy;
  chan_t  chan;
  bin_t   bin_idx;
  logic   xfer;
  logic   final_beat;

  assign final_beat = (chan == LastChan) && (bin_idx == LastBin);
  assign xfer       = hist.valid && hist.ready;

  assign hist.valid       = busy;
  assign hist.channel     = chan;
  assign hist.bin         = bin_idx;
  assign hist.count       = shadow[0];
  assign hist.last_result = final_beat;

  assign stat.busy       = busy;
  assign stat.final_beat = final_beat;

  // Track the drain sequence.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      chan    <= '0;
      bin_idx <= '0;
    end else if (load) begin
      busy    <= 1'b1;
      chan    <= '0;
      bin_idx <= '0;
    end else if (xfer) begin
      if (final_beat) busy <= 1'b0;
      if (bin_idx == LastBin) begin
        bin_idx <= '0;
        chan    <= chan + chan_t'(1);
      end else begin
        bin_idx <= bin_idx + bin_t'(1);
      end
    end
  end

  // Load the snapshot or shift it by one count.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < TotalBins; i++) shadow[i] <= load_counts[i];
    end else if (xfer) begin
      for (int i = 0; i < TotalBins - 1; i++) shadow[i] <= shadow[i+1];
      shadow[TotalBins-1] <= '0;
    end
  end
endmodule
`default_nettype wire

[rtl/core/rgb_window_color_histogram.sv]
// Per-channel 12-bin color histogram of a pixel window, top level.
//
// Takes one RGB pixel per clock. Three lanes, one per channel, bin their
// byte and bump a saturating counter (cap 512). A pixel marked last of the
// window is counted, then all 36 counts are copied into a drain register in
// the same cycle and the lanes restart from zero, so the next window streams
// in without a gap. The drain sends 36 counts, channel 0 bins 0..11 first,
// one per output transfer, flagging the final one. A last pixel is held off
// (ready low) while the previous window's 36 counts are still draining,
// including the cycle of the final count transfer. With the receiver always
// ready, the next last pixel is therefore taken only once all counts of the
// previous window are sent, and no count is output while it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rgb_window_color_histogram (
  input  wire logic    clk,
  input  wire logic    rst,
  rgbh_pix_if.sink     pix,
  rgbh_hist_if.source  hist
);
  import rgbh_pkg::*;

  logic        take;
  logic        load;
  drain_stat_t stat;
  byte_t       lane_byte   [ChanCount];
  count_t      lane_counts [ChanCount][BinCount];
  count_t      all_counts  [TotalBins];

  // Stall a last pixel only while the drain register is occupied.
  assign pix.ready = !(stat.busy && pix.last_pixel);
  assign take      = pix.valid && pix.ready;
  assign load      = take && pix.last_pixel;

  assign lane_byte[0] = pix.red;
  assign lane_byte[1] = pix.green;
  assign lane_byte[2] = pix.blue;

  for (genvar c = 0; c < ChanCount; c++) begin : g_lane
    rgbh_lane u_lane (
      .clk         (clk),
      .rst         (rst),
      .take        (take),
      .clear       (load),
      .value       (lane_byte[c]),
      .counts_next (lane_counts[c])
    );
    for (genvar b = 0; b < BinCount; b++) begin : g_bin
      assign all_counts[c*BinCount + b] = lane_counts[c][b];
    end
  end

  rgbh_drain u_drain (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .load_counts (all_counts),
    .stat        (stat),
    .hist        (hist)
  );

  `ASSERT_NEXT(a_load_starts_drain, clk, rst, load,
               hist.valid && hist.channel == '0 && hist.bin == '0)
  `ASSERT_SAME(a_last_at_end, clk, rst, hist.valid && hist.last_result,
               hist.channel == LastChan && hist.bin == LastBin)
  `ASSERT_SAME(a_count_capped, clk, rst, hist.valid, hist.count <= CountCap)
  `ASSERT_SAME(a_stall_only_busy, clk, rst, !pix.ready, stat.busy && hist.valid)
  `ASSERT_NEXT(a_final_frees, clk, rst,
               hist.valid && hist.ready && stat.final_beat && !load, !stat.busy)
endmodule
`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the per-channel color histogram block.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import rgbh_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 300;
  localparam int DrainSlack = 40;
  localparam int ReportMax  = 10;

  // Lower edge of each color bin.
  localparam byte_t BinEdge [BinCount] = '{
    8'd0, 8'd21, 8'd42, 8'd64, 8'd85, 8'd106,
    8'd128, 8'd149, 8'd170, 8'd192, 8'd213, 8'd234
  };

  // One count transfer as the block should send it.
  typedef struct packed {
    chan_t  channel;
    bin_t   bin;
    count_t count;
    logic   last_result;
  } hist_beat_t;

  // One directed pixel; bins are typed in for one-pixel windows only.
  typedef struct packed {
    byte_t red;
    byte_t green;
    byte_t blue;
    logic  last_pixel;
    logic  typed;
    bin_t  red_bin;
    bin_t  green_bin;
    bin_t  blue_bin;
  } pixel_row_t;

  localparam int RowCount = 16;
  localparam pixel_row_t PixelRows [RowCount] = '{
    // one-pixel windows right after reset and after each drain
    '{8'd0,   8'd0,   8'd0,   1'b1, 1'b1, 4'd0,  4'd0,  4'd0},
    '{8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 4'd11, 4'd11, 4'd11},
    '{8'd20,  8'd21,  8'd41,  1'b1, 1'b1, 4'd0,  4'd1,  4'd1},
    '{8'd42,  8'd63,  8'd64,  1'b1, 1'b1, 4'd2,  4'd2,  4'd3},
    '{8'd84,  8'd85,  8'd105, 1'b1, 1'b1, 4'd3,  4'd4,  4'd4},
    '{8'd106, 8'd127, 8'd128, 1'b1, 1'b1, 4'd5,  4'd5,  4'd6},
    '{8'd148, 8'd149, 8'd169, 1'b1, 1'b1, 4'd6,  4'd7,  4'd7},
    '{8'd170, 8'd191, 8'd192, 1'b1, 1'b1, 4'd8,  4'd8,  4'd9},
    '{8'd212, 8'd213, 8'd233, 1'b1, 1'b1, 4'd9,  4'd10, 4'd10},
    '{8'd234, 8'd233, 8'd0,   1'b1, 1'b1, 4'd11, 4'd10, 4'd0},
    // multi-pixel windows, checked by the predictor
    '{8'd10,  8'd100, 8'd200, 1'b0, 1'b0, 4'd0,  4'd0,  4'd0},
    '{8'd10,  8'd100, 8'd200, 1'b0, 1'b0, 4'd0,  4'd0,  4'd0},
    '{8'd250, 8'd5,   8'd130, 1'b1, 1'b0, 4'd0,  4'd0,  4'd0},
    '{8'hAA,  8'h55,  8'hFF,  1'b0, 1'b0, 4'd0,  4'd0,  4'd0},
    '{8'h55,  8'hAA,  8'h00,  1'b0, 1'b0, 4'd0,  4'd0,  4'd0},
    '{8'hFF,  8'h00,  8'h80,  1'b1, 1'b0, 4'd0,  4'd0,  4'd0}
  };

  logic clk;
  logic rst;

  rgbh_pix_if  pix ();
  rgbh_hist_if hist ();

  rgb_window_color_histogram uut (
    .clk  (clk),
    .rst  (rst),
    .pix  (pix),
    .hist (hist)
  );

  // Sideband for the pixel on the bus: typed-in bins, if any.
  logic cur_typed;
  bin_t cur_red_bin;
  bin_t cur_green_bin;
  bin_t cur_blue_bin;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;

  count_t     window_tally [ChanCount][BinCount];
  hist_beat_t expected_counts [$];
  int         mismatches;
  int         pixels_accepted;
  int         windows_closed;
  int         counts_checked;
  int         cycle_count;

  // Generate the clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // End the run if it hangs.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d counts still due",
               cycle_count, expected_counts.size());
      $display("testbench failed");
      $finish;
    end
  end

  function automatic bin_t color_bin(input byte_t v);
    for (int k = BinCount - 1; k > 0; k--) begin
      if (v >= BinEdge[k]) return bin_t'(k);
    end
    return '0;
  endfunction

  // Bump one saturating tally entry.
  function automatic void tally_byte(input int ch, input byte_t v);
    bin_t b;
    b = color_bin(v);
    if (window_tally[ch][b] < CountCap) window_tally[ch][b] = window_tally[ch][b] + 1'b1;
  endfunction

  // Queue the 36 counts of a closed window, then clear the tally.
  function automatic void close_window(input logic typed, input bin_t rb, input bin_t gb,
                                       input bin_t bb);
    hist_beat_t beat;
    bin_t       hit [ChanCount];
    hit[0] = rb;
    hit[1] = gb;
    hit[2] = bb;
    for (int ch = 0; ch < ChanCount; ch++) begin
      for (int b = 0; b < BinCount; b++) begin
        beat.channel     = chan_t'(ch);
        beat.bin         = bin_t'(b);
        beat.count       = typed ? count_t'(hit[ch] == bin_t'(b)) : window_tally[ch][b];
        beat.last_result = (ch == ChanCount - 1) && (b == BinCount - 1);
        expected_counts.push_back(beat);
        window_tally[ch][b] = '0;
      end
    end
  endfunction

  task automatic note_mismatch(input string what, input hist_beat_t want,
                               input hist_beat_t got);
    mismatches++;
    if (mismatches <= ReportMax) begin
      $display("%0t: %s: expected ch %0d bin %0d count %0d last %0d, got ch %0d bin %0d count %0d last %0d",
               $realtime, what, want.channel, want.bin, want.count, want.last_result,
               got.channel, got.bin, got.count, got.last_result);
    end
  endtask

  // Predict on each pixel transfer, then check each count transfer.
  always @(posedge clk) begin
    hist_beat_t got;
    if (!rst) begin
      if (pix.valid && pix.ready) begin
        pixels_accepted++;
        tally_byte(0, pix.red);
        tally_byte(1, pix.green);
        tally_byte(2, pix.blue);
        if (pix.last_pixel) begin
          windows_closed++;
          close_window(cur_typed, cur_red_bin, cur_green_bin, cur_blue_bin);
        end
      end
      if (hist.valid && hist.ready) begin
        got = '{hist.channel, hist.bin, hist.count, hist.last_result};
        counts_checked++;
        if (expected_counts.size() == 0) begin
          note_mismatch("count with nothing due", '0, got);
        end else if (got !== expected_counts[0]) begin
          note_mismatch("count mismatch", expected_counts[0], got);
          void'(expected_counts.pop_front());
        end else begin
          void'(expected_counts.pop_front());
        end
      end
    end
  end

  // Drive ready; hold it low for a long stretch on request.
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    hist.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        hist.ready <= 1'b0;
      end else begin
        hist.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one pixel, idling at random first, and wait for its transfer.
  task automatic send_pixel(input byte_t r, input byte_t g, input byte_t b,
                            input logic last, input logic typed, input bin_t rb,
                            input bin_t gb, input bin_t bb);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid      <= 1'b1;
    pix.red        <= r;
    pix.green      <= g;
    pix.blue       <= b;
    pix.last_pixel <= last;
    cur_typed      <= typed;
    cur_red_bin    <= rb;
    cur_green_bin  <= gb;
    cur_blue_bin   <= bb;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
  endtask

  task automatic lower_valid();
    pix.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_counts.size() != 0) @(posedge clk);
  endtask

  // Mix of full-range bytes, bytes around bin edges and extremes.
  function automatic byte_t rand_byte();
    int pick;
    int v;
    pick = $urandom_range(99);
    if (pick < 50) return byte_t'($urandom_range(255));
    if (pick < 75) begin
      v = int'(BinEdge[$urandom_range(BinCount - 1)]) + int'($urandom_range(2)) - 1;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return byte_t'(v);
    end
    return $urandom_range(1) ? 8'hFF : 8'h00;
  endfunction

  // Stream random windows, mostly short, until the item goal is met.
  task automatic send_random_windows(input int item_goal);
    int sent;
    int len;
    int pick;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(99);
      if (pick < 10) len = 1;
      else if (pick < 80) len = $urandom_range(6, 2);
      else len = $urandom_range(40, 7);
      for (int p = 0; p < len; p++) begin
        send_pixel(rand_byte(), rand_byte(), rand_byte(), p == len - 1, 1'b0, '0, '0, '0);
      end
      sent += len;
    end
  endtask

  // Main sequence.
  initial begin
    pixel_row_t row;
    mismatches      = 0;
    pixels_accepted = 0;
    windows_closed  = 0;
    counts_checked  = 0;
    for (int ch = 0; ch < ChanCount; ch++) begin
      for (int b = 0; b < BinCount; b++) window_tally[ch][b] = '0;
    end
    send_idle_pct  = 32;
    recv_idle_pct  <= 63;
    hold_req       <= 0;
    rst            <= 1'b1;
    pix.valid      <= 1'b0;
    pix.red        <= '0;
    pix.green      <= '0;
    pix.blue       <= '0;
    pix.last_pixel <= 1'b0;
    cur_typed      <= 1'b0;
    cur_red_bin    <= '0;
    cur_green_bin  <= '0;
    cur_blue_bin   <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed rows.
    for (int i = 0; i < RowCount; i++) begin
      row = PixelRows[i];
      send_pixel(row.red, row.green, row.blue, row.last_pixel, row.typed,
                 row.red_bin, row.green_bin, row.blue_bin);
    end

    // Run a window past the cap so the hit counters saturate.
    for (int p = 0; p < WindowPixels + 18; p++) begin
      send_pixel(8'd100, 8'd0, 8'd255, p == WindowPixels + 17, 1'b0, '0, '0, '0);
    end
    lower_valid();
    wait_drained();

    // Hold off the receiver and close four windows so that the input stalls.
    hold_req <= hold_req + 1;
    @(posedge clk);
    for (int w = 0; w < 4; w++) begin
      for (int p = 0; p < 3; p++) begin
        send_pixel(rand_byte(), rand_byte(), rand_byte(), p == 2, 1'b0, '0, '0, '0);
      end
    end
    lower_valid();
    wait_drained();

    send_random_windows(40);
    lower_valid();
    wait_drained();

    // Swap the idle rates.
    send_idle_pct = 63;
    recv_idle_pct <= 32;
    send_random_windows(40);
    lower_valid();
    wait_drained();

    // Back-to-back with no idling.
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    send_random_windows(40);
    lower_valid();
    wait_drained();
    repeat (DrainSlack) @(posedge clk);

    $display("covered %0d pixels in %0d windows, %0d count transfers checked",
             pixels_accepted, windows_closed, counts_checked);
    $display("including bin edges, a saturating window and a long output stall; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_counts.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
